// ----- rtl/occupancy_grid_accumulator_macros.svh -----
// Assertion macros shared by the occupancy grid accumulator RTL.
// Has no dependencies; included by the files that carry assertions.
`ifndef OCCUPANCY_GRID_ACCUMULATOR_MACROS_SVH
`define OCCUPANCY_GRID_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OGACC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OGACC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ogacc_pkg.sv -----
// Shared types and constants of the occupancy grid accumulator.
// Has no dependencies; used by every RTL module of the block.
package ogacc_pkg;

    localparam int GRID_ROWS_DEF = 128;
    localparam int GRID_COLS_DEF = 128;

    localparam int COUNT_W  = 32;
    localparam int RATIO_W  = 17;
    localparam int THRESH_W = 17;
    localparam int DIV_CNT_W = $clog2(RATIO_W);

    localparam logic [RATIO_W-1:0]  RATIO_ONE            = 17'h10000;
    localparam logic [THRESH_W-1:0] FREE_THRESHOLD_RESET = 17'd22938;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 88;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_FREE_THRESHOLD = 1'b0;

    typedef enum logic [1:0] {
        OP_EMPTY    = 2'd0,
        OP_OCCUPIED = 2'd1,
        OP_QUERY    = 2'd2
    } t_opcode;

    typedef struct packed {
        logic       rd;
        logic       upd;
        logic [1:0] op;
    } t_cell_cmd;

    typedef struct packed {
        logic [COUNT_W-1:0] occ;
        logic [COUNT_W-1:0] empty;
    } t_cell_cnt;

    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] num;
        logic [COUNT_W:0]   den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [RATIO_W-1:0] quo;
    } t_div_rsp;

endpackage

// ----- rtl/ogacc_cells.sv -----
// Cell counter store: one synchronous memory of counter pairs, the clearing
// sweep after reset and the saturating read-modify-write. Depends on ogacc_pkg.
module ogacc_cells #(
    parameter int GRID_CELLS = ogacc_pkg::GRID_ROWS_DEF * ogacc_pkg::GRID_COLS_DEF,
    parameter int ADDR_W     = $clog2(ogacc_pkg::GRID_ROWS_DEF * ogacc_pkg::GRID_COLS_DEF)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ogacc_pkg::t_cell_cmd i_cmd,
    input  logic [ADDR_W-1:0]    i_addr,
    output ogacc_pkg::t_cell_cnt o_cnt,
    output logic                 o_clr_busy
);

    ogacc_pkg::t_cell_cnt r_mem [GRID_CELLS];
    ogacc_pkg::t_cell_cnt r_rdata;
    ogacc_pkg::t_cell_cnt n_cnt;
    logic                 r_clr_busy;
    logic [ADDR_W-1:0]    r_clr_addr;
    logic                 w_we;
    logic [ADDR_W-1:0]    w_waddr;
    ogacc_pkg::t_cell_cnt w_wdata;

    // The sweep writes one zero pair per cycle until the last cell is done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(GRID_CELLS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Saturating increment of the counter that the opcode selects.
    always_comb begin
        n_cnt = r_rdata;
        unique case (i_cmd.op)
            ogacc_pkg::OP_EMPTY: begin
                if (r_rdata.empty != '1) begin
                    n_cnt.empty = r_rdata.empty + ogacc_pkg::COUNT_W'(1);
                end
            end
            ogacc_pkg::OP_OCCUPIED: begin
                if (r_rdata.occ != '1) begin
                    n_cnt.occ = r_rdata.occ + ogacc_pkg::COUNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign w_we    = r_clr_busy || i_cmd.upd;
    assign w_waddr = r_clr_busy ? r_clr_addr : i_addr;
    assign w_wdata = r_clr_busy ? '0 : n_cnt;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_cnt      = n_cnt;
    assign o_clr_busy = r_clr_busy;

endmodule

// ----- rtl/ogacc_div.sv -----
// Restoring radix-2 divider for the occupied ratio, one quotient bit per cycle.
// Depends on ogacc_pkg for the request and response structs.
module ogacc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ogacc_pkg::t_div_req i_req,
    output ogacc_pkg::t_div_rsp o_rsp
);

    localparam int CW = ogacc_pkg::COUNT_W;
    localparam int QW = ogacc_pkg::RATIO_W;

    logic [CW:0]                       r_rem;
    logic [CW:0]                       r_div;
    logic [QW-1:0]                     r_quo;
    logic [ogacc_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic                              r_busy;
    logic                              r_first;
    logic                              r_done;
    logic [CW+1:0]                     w_trial;
    logic [CW+1:0]                     w_diff;
    logic                              w_ge;

    // The numerator never exceeds the divisor, so the first step compares the
    // numerator itself and yields the integer bit; later steps shift in zeros.
    assign w_trial = r_first ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= ogacc_pkg::DIV_CNT_W'(QW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - ogacc_pkg::DIV_CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem   <= {1'b0, i_req.num};
            r_div   <= i_req.den;
            r_first <= 1'b1;
        end else if (r_busy) begin
            r_rem   <= w_ge ? w_diff[CW:0] : w_trial[CW:0];
            r_quo   <= {r_quo[QW-2:0], w_ge};
            r_first <= 1'b0;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ----- rtl/occupancy_grid_accumulator.sv -----
// Top level of the occupancy grid accumulator: stream ports, APB register,
// item sequencer and output register. Depends on ogacc_pkg, ogacc_cells, ogacc_div.
//
// Usage. Items arrive on the s_axis channel, one beat each, and every item
// yields exactly one result beat on the m_axis channel. An item counts an
// empty hit, counts an occupied hit or just queries the cell at (row, col).
// The free threshold is a single APB register at byte address 0; write it
// only while no item is in flight. Reads return the current threshold.
// After reset the block sweeps the counter memory to zero, one cell per
// cycle; s_axis stays not ready during the sweep while APB writes are
// taken as usual. An item inside the grid is accepted in S_IDLE, its cell
// is read in S_ADDR and written back in S_MOD, and the 17-step serial
// divider is started in S_START and forms the ratio in S_DIV; the result
// is loaded into the output register in S_DONE. The next item is taken
// only after that load. An item outside the grid touches no memory and
// goes straight from S_IDLE to S_DONE.
// The result sits in an output register; while the receiver stalls the
// block still accepts and works on the next item, and waits only when that
// next result is ready and the register is still full.
`include "occupancy_grid_accumulator_macros.svh"

module occupancy_grid_accumulator #(
    parameter int GRID_ROWS = ogacc_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = ogacc_pkg::GRID_COLS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input beat, from bit 0 up: opcode[1:0], row[17:2], col[33:18], zero pad.
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [ogacc_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // Result beat, from bit 0 up: in_map[0], known[1], occupied_ratio[18:2],
    // is_free[19], empty_hits[51:20], occupied_hits[83:52], zero pad.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [ogacc_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ogacc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ogacc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ogacc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W     = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
    localparam int ROW_W      = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int COL_W      = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int CW         = ogacc_pkg::COUNT_W;
    localparam int QW         = ogacc_pkg::RATIO_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ADDR  = 6'b000010,
        S_MOD   = 6'b000100,
        S_START = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                        r_state;
    t_state                        n_state;

    // Registered item and cell values.
    logic [1:0]                    r_op;
    logic [ROW_W-1:0]              r_row;
    logic [COL_W-1:0]              r_col;
    logic                          r_in_map;
    logic [ADDR_W-1:0]             r_idx;
    logic [CW-1:0]                 r_empty;
    logic [CW-1:0]                 r_occ;
    logic [ogacc_pkg::THRESH_W-1:0] r_thresh;

    // Output register.
    logic                          r_out_valid;
    logic                          r_out_in_map;
    logic                          r_out_known;
    logic [QW-1:0]                 r_out_ratio;
    logic                          r_out_free;
    logic [CW-1:0]                 r_out_empty;
    logic [CW-1:0]                 r_out_occ;

    logic [15:0]                   w_row;
    logic [15:0]                   w_col;
    logic                          w_in_map;
    logic                          w_accept;
    logic                          w_load;
    logic [ADDR_W-1:0]             w_idx;
    logic                          w_known;
    logic [QW-1:0]                 w_ratio;
    logic                          w_clr_busy;
    logic                          w_cfg_wr;
    logic [ogacc_pkg::APB_ADDR_W-3:0] w_reg_idx;

    ogacc_pkg::t_cell_cmd          w_cell_cmd;
    ogacc_pkg::t_cell_cnt          w_cell_cnt;
    ogacc_pkg::t_div_req           w_div_req;
    ogacc_pkg::t_div_rsp           w_div_rsp;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ogacc_pkg::APB_ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign prdata    = (w_reg_idx == ogacc_pkg::REG_FREE_THRESHOLD) ?
                       ogacc_pkg::APB_DATA_W'(r_thresh) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= ogacc_pkg::FREE_THRESHOLD_RESET;
        end else if (w_cfg_wr && (w_reg_idx == ogacc_pkg::REG_FREE_THRESHOLD)) begin
            r_thresh <= pwdata[ogacc_pkg::THRESH_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    assign w_row = i_s_axis_tdata[17:2];
    assign w_col = i_s_axis_tdata[33:18];

    // A negative coordinate reads as 32768 or more when taken as unsigned,
    // which is beyond any grid size, so one unsigned compare per axis does.
    assign w_in_map = (w_row < 16'(GRID_ROWS)) && (w_col < 16'(GRID_COLS));

    assign o_s_axis_tready = (r_state == S_IDLE) && !w_clr_busy;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Row-major cell index; the coordinates are already known to be in range.
    assign w_idx = ADDR_W'(ADDR_W'(r_row) * ADDR_W'(GRID_COLS) + ADDR_W'(r_col));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign w_load = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_in_map ? S_ADDR : S_DONE;
                end
            end
            S_ADDR:  n_state = S_MOD;
            S_MOD:   n_state = S_START;
            S_START: n_state = S_DIV;
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Item fields and the cell's counts after the update. An item outside
    // the grid leaves both counts at zero, which makes the whole result zero.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_s_axis_tdata[1:0];
            r_row    <= w_row[ROW_W-1:0];
            r_col    <= w_col[COL_W-1:0];
            r_in_map <= w_in_map;
            r_empty  <= '0;
            r_occ    <= '0;
        end
        if (r_state == S_ADDR) begin
            r_idx <= w_idx;
        end
        if (r_state == S_MOD) begin
            r_empty <= w_cell_cnt.empty;
            r_occ   <= w_cell_cnt.occ;
        end
    end

    // The read is issued in S_ADDR and its data is modified and written back
    // in S_MOD. Items run one at a time, so no two accesses overlap.
    assign w_cell_cmd.rd  = (r_state == S_ADDR);
    assign w_cell_cmd.upd = (r_state == S_MOD);
    assign w_cell_cmd.op  = r_op;

    ogacc_cells #(
        .GRID_CELLS (GRID_CELLS),
        .ADDR_W     (ADDR_W)
    ) u_cells (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cell_cmd),
        .i_addr     ((r_state == S_ADDR) ? w_idx : r_idx),
        .o_cnt      (w_cell_cnt),
        .o_clr_busy (w_clr_busy)
    );

    // Ratio = floor(occ * 2^16 / (empty + occ)), total formed on 33 bits.
    assign w_div_req.start = (r_state == S_START);
    assign w_div_req.num   = r_occ;
    assign w_div_req.den   = {1'b0, r_empty} + {1'b0, r_occ};

    ogacc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ------------------------------------------------------------------
    // Result and output register
    // ------------------------------------------------------------------
    // An unknown cell has a zero divisor; its quotient is meaningless and
    // is replaced by zero here.
    assign w_known = (r_empty != '0) || (r_occ != '0);
    assign w_ratio = w_known ? w_div_rsp.quo : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_in_map <= r_in_map;
            r_out_known  <= w_known;
            r_out_ratio  <= w_ratio;
            r_out_free   <= w_known && (w_ratio < r_thresh);
            r_out_empty  <= r_empty;
            r_out_occ    <= r_occ;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_occ, r_out_empty, r_out_free,
                              r_out_ratio, r_out_known, r_out_in_map};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `OGACC_ASSERT_IMPL(a_off_map_zero, i_clk, i_rst_n,
        o_m_axis_tvalid && !r_out_in_map,
        (r_out_empty == '0) && (r_out_occ == '0) && !r_out_known,
        "result outside the grid carries nonzero counts")
    `OGACC_ASSERT_IMPL(a_free_known, i_clk, i_rst_n,
        o_m_axis_tvalid && r_out_free, r_out_known,
        "free flag set on an unknown cell")
    `OGACC_ASSERT_IMPL(a_ratio_range, i_clk, i_rst_n,
        o_m_axis_tvalid, r_out_ratio <= ogacc_pkg::RATIO_ONE,
        "occupied ratio above one")
    `OGACC_ASSERT_IMPL(a_div_done_state, i_clk, i_rst_n,
        w_div_rsp.done, r_state == S_DIV,
        "divider finished while the sequencer was not waiting")
    `OGACC_ASSERT_NEXT(a_one_item, i_clk, i_rst_n,
        w_accept, !o_s_axis_tready,
        "second item taken while one is in flight")

endmodule
